// ===== hw/rtl/spt_pkg.sv =====
// Shared types and constants of the stepped pulse train generator.
`default_nettype none

package spt_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SEG_W      = 13;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_BASE     = 3'd0,
    REG_WIDTH_STEP  = 3'd1,
    REG_OFF_TIME    = 3'd2,
    REG_PULSE_COUNT = 3'd3,
    REG_GAP_TIME    = 3'd4,
    REG_SYNC_WIDTH  = 3'd5,
    REG_TIME_SCALE  = 3'd6
  } reg_idx_t;

  // Reset values of the configuration registers
  localparam logic [11:0] RST_ON_BASE     = 12'd700;
  localparam logic [7:0]  RST_WIDTH_STEP  = 8'd50;
  localparam logic [11:0] RST_OFF_TIME    = 12'd500;
  localparam logic [3:0]  RST_PULSE_COUNT = 4'd9;
  localparam logic [12:0] RST_GAP_TIME    = 13'd2500;
  localparam logic [9:0]  RST_SYNC_WIDTH  = 10'd50;
  localparam logic [9:0]  RST_TIME_SCALE  = 10'd1;

  typedef struct packed {
    logic [11:0] on_base;
    logic [7:0]  width_step;
    logic [11:0] off_time;
    logic [3:0]  pulse_count;
    logic [12:0] gap_time;
    logic [9:0]  sync_width;
    logic [9:0]  time_scale;
  } cfg_t;

  // Frame phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HIGH = 5'b00010,
    PH_LOW  = 5'b00100,
    PH_GAP  = 5'b01000,
    PH_SYNC = 5'b10000
  } phase_t;

  typedef struct packed {
    logic data_level;
    logic sync_level;
    logic frame_end;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spt_cfg.sv =====
// Configuration register file of the stepped pulse train generator.
`default_nettype none

module spt_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                wr_en,
  input  wire logic [spt_pkg::CFG_IDX_W-1:0]       wr_idx,
  input  wire logic [spt_pkg::CFG_DATA_W-1:0]      wr_data,
  output spt_pkg::cfg_t                            cfg
);

  spt_pkg::cfg_t cfg_r;
  spt_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (spt_pkg::reg_idx_t'(wr_idx))
        spt_pkg::REG_ON_BASE:     cfg_nxt.on_base     = wr_data[11:0];
        spt_pkg::REG_WIDTH_STEP:  cfg_nxt.width_step  = wr_data[7:0];
        spt_pkg::REG_OFF_TIME:    cfg_nxt.off_time    = wr_data[11:0];
        spt_pkg::REG_PULSE_COUNT: cfg_nxt.pulse_count = wr_data[3:0];
        spt_pkg::REG_GAP_TIME:    cfg_nxt.gap_time    = wr_data[12:0];
        spt_pkg::REG_SYNC_WIDTH:  cfg_nxt.sync_width  = wr_data[9:0];
        spt_pkg::REG_TIME_SCALE:  cfg_nxt.time_scale  = wr_data[9:0];
        default:                  cfg_nxt = cfg_r; // unmapped index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_base     <= spt_pkg::RST_ON_BASE;
      cfg_r.width_step  <= spt_pkg::RST_WIDTH_STEP;
      cfg_r.off_time    <= spt_pkg::RST_OFF_TIME;
      cfg_r.pulse_count <= spt_pkg::RST_PULSE_COUNT;
      cfg_r.gap_time    <= spt_pkg::RST_GAP_TIME;
      cfg_r.sync_width  <= spt_pkg::RST_SYNC_WIDTH;
      cfg_r.time_scale  <= spt_pkg::RST_TIME_SCALE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/spt_seg.sv =====
// Segment length in time units for the current phase and pulse.
`default_nettype none

module spt_seg (
  input  wire spt_pkg::cfg_t                  cfg,
  input  wire spt_pkg::phase_t                phase,
  input  wire logic [3:0]                     pulse_idx,
  input  wire logic                           reversed,
  output logic [spt_pkg::SEG_W-1:0]           seg_units
);

  logic [3:0]  count1;
  logic [4:0]  idx_p1;
  logic [3:0]  k;
  logic [11:0] on1;
  logic [11:0] off1;
  logic [9:0]  sync1;
  logic [11:0] prod;

  always_comb begin
    count1 = (cfg.pulse_count == 4'd0) ? 4'd1 : cfg.pulse_count;
    on1    = (cfg.on_base == 12'd0) ? 12'd1 : cfg.on_base;
    off1   = (cfg.off_time == 12'd0) ? 12'd1 : cfg.off_time;
    sync1  = (cfg.sync_width == 10'd0) ? 10'd1 : cfg.sync_width;
    idx_p1 = {1'b0, pulse_idx} + 5'd1;

    // Reversed order counts the width index down, saturating at zero
    if (reversed) begin
      k = (idx_p1 >= {1'b0, count1}) ? 4'd0 : count1 - 4'd1 - pulse_idx;
    end else begin
      k = pulse_idx;
    end
    prod = {8'd0, k} * {4'd0, cfg.width_step};

    unique case (phase)
      spt_pkg::PH_HIGH: seg_units = {1'b0, on1} + {1'b0, prod};
      spt_pkg::PH_LOW:  seg_units = {1'b0, off1};
      spt_pkg::PH_GAP:  seg_units = cfg.gap_time;
      spt_pkg::PH_SYNC: seg_units = {3'd0, sync1};
      default:          seg_units = 13'd1;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spt_seq.sv =====
// Frame sequencer: toggle latching, prescaler, unit counter and phase control.
`default_nettype none

module spt_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           toggle_enable,
  input  wire logic           toggle_order,
  input  wire spt_pkg::cfg_t  cfg,
  output spt_pkg::res_t       res
);

  logic                     enabled_r, enabled_nxt;
  logic                     reversed_r, reversed_nxt;
  logic                     pend_en_r, pend_en_nxt;
  logic                     pend_ord_r, pend_ord_nxt;
  spt_pkg::phase_t          phase_r, phase_nxt;
  logic [3:0]               idx_r, idx_nxt;
  logic [12:0]              cnt_r, cnt_nxt;
  logic [9:0]               presc_r, presc_nxt;

  spt_pkg::phase_t          ph_a;
  logic [3:0]               idx_a;
  logic [12:0]              cnt_a;
  logic [9:0]               presc_a;
  logic [10:0]              presc_inc;
  logic [9:0]               ts1;
  logic [3:0]               count1;
  logic [4:0]               idx_p1;
  logic                     wrap;
  logic [12:0]              cnt_new;
  logic [spt_pkg::SEG_W-1:0] seg_units;
  logic                     done;

  spt_seg u_seg (
    .cfg       (cfg),
    .phase     (ph_a),
    .pulse_idx (idx_a),
    .reversed  (reversed_nxt),
    .seg_units (seg_units)
  );

  always_comb begin
    pend_en_nxt  = pend_en_r ^ toggle_enable;
    pend_ord_nxt = pend_ord_r ^ toggle_order;
    enabled_nxt  = enabled_r;
    reversed_nxt = reversed_r;
    ph_a         = phase_r;
    idx_a        = idx_r;
    cnt_a        = cnt_r;
    presc_a      = presc_r;

    // Frame boundary: apply latched flips, start a frame on this same tick
    if (phase_r == spt_pkg::PH_IDLE) begin
      enabled_nxt  = enabled_r ^ pend_en_nxt;
      reversed_nxt = reversed_r ^ pend_ord_nxt;
      pend_en_nxt  = 1'b0;
      pend_ord_nxt = 1'b0;
      if (enabled_nxt) begin
        ph_a    = spt_pkg::PH_HIGH;
        idx_a   = 4'd0;
        cnt_a   = 13'd0;
        presc_a = 10'd0;
      end
    end

    ts1       = (cfg.time_scale == 10'd0) ? 10'd1 : cfg.time_scale;
    count1    = (cfg.pulse_count == 4'd0) ? 4'd1 : cfg.pulse_count;
    idx_p1    = {1'b0, idx_a} + 5'd1;
    presc_inc = {1'b0, presc_a} + 11'd1;
    wrap      = (presc_inc >= {1'b0, ts1});
    cnt_new   = wrap ? cnt_a + 13'd1 : cnt_a;
    done      = wrap && (cnt_new >= seg_units);

    phase_nxt = ph_a;
    idx_nxt   = idx_a;
    cnt_nxt   = cnt_a;
    presc_nxt = presc_a;
    res       = '0;

    if (ph_a != spt_pkg::PH_IDLE) begin
      res.data_level = (ph_a == spt_pkg::PH_HIGH);
      res.sync_level = (ph_a == spt_pkg::PH_SYNC);
      cnt_nxt        = cnt_new;
      presc_nxt      = wrap ? 10'd0 : presc_inc[9:0];
      if (done) begin
        cnt_nxt   = 13'd0;
        presc_nxt = 10'd0;
        unique case (ph_a)
          spt_pkg::PH_HIGH: phase_nxt = spt_pkg::PH_LOW;
          spt_pkg::PH_LOW: begin
            if (idx_p1 < {1'b0, count1}) begin
              idx_nxt   = idx_p1[3:0];
              phase_nxt = spt_pkg::PH_HIGH;
            end else if (cfg.gap_time == 13'd0) begin
              phase_nxt = spt_pkg::PH_SYNC;
            end else begin
              phase_nxt = spt_pkg::PH_GAP;
            end
          end
          spt_pkg::PH_GAP: phase_nxt = spt_pkg::PH_SYNC;
          spt_pkg::PH_SYNC: begin
            res.frame_end = 1'b1;
            phase_nxt     = spt_pkg::PH_IDLE;
            idx_nxt       = 4'd0;
          end
          default: phase_nxt = spt_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      reversed_r <= 1'b0;
      pend_en_r  <= 1'b0;
      pend_ord_r <= 1'b0;
      phase_r    <= spt_pkg::PH_IDLE;
      idx_r      <= 4'd0;
      cnt_r      <= 13'd0;
      presc_r    <= 10'd0;
    end else if (step) begin
      enabled_r  <= enabled_nxt;
      reversed_r <= reversed_nxt;
      pend_en_r  <= pend_en_nxt;
      pend_ord_r <= pend_ord_nxt;
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      cnt_r      <= cnt_nxt;
      presc_r    <= presc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stepped_pulse_train_generator.sv =====
// Top level of the stepped pulse train generator: handshake, result register, checks.
// Output: the result of a tick is registered and is on the out_ port in the cycle after its input transfer.
// Throughput: one tick per cycle; a new tick is taken while the result register is
//   empty or is being drained in the same cycle, so the sequencer never waits on itself.
// Reset (rst_n low, synchronous): output disabled, normal order, no pending flips,
//   sequencer idle, registers back to their default values, result register empty.
`default_nettype none

module stepped_pulse_train_generator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // tick input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_toggle_enable,
  input  wire logic                             in_toggle_order,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_data_level,
  output logic                                  out_sync_level,
  output logic                                  out_frame_end,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [spt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  spt_pkg::cfg_t cfg;
  spt_pkg::res_t res;
  spt_pkg::res_t res_r;
  logic          out_valid_r, out_valid_nxt;
  logic          in_xfer;
  logic          cfg_xfer;

  // Registers are always writable; the user must write them only while the block is idle, the block does not enforce it
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Take a tick when the result register is free or drains this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  spt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_xfer),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // The sequencer advances exactly once per accepted tick
  spt_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_xfer),
    .toggle_enable (in_toggle_enable),
    .toggle_order  (in_toggle_order),
    .cfg           (cfg),
    .res           (res)
  );

  // Result register: load on an input transfer, drop on an output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds unless a new tick is taken
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_level = res_r.data_level;
  assign out_sync_level = res_r.sync_level;
  assign out_frame_end  = res_r.frame_end;

  // Every accepted tick leaves a result in the register
  a_xfer_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted tick produced no result");

  // Data and sync lines are never high together
  a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.data_level && res_r.sync_level))
    else $error("data and sync high at once");

  // A frame ends only on a sync tick
  a_end_on_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_end) |-> res_r.sync_level)
    else $error("frame end outside sync pulse");

endmodule

`default_nettype wire
